// ===== rtl/core/pcurve_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcurve_pkg: shared types and constants of the throttle curve
// Widths, fixed scale constants, register indexes and the side-band struct
// that rides along the datapath.
// ----------------------------------------------------------------------------
package pcurve_pkg;

    localparam int CMD_W   = 16;  // signed command
    localparam int MAG_W   = 7;   // magnitude 0..100, also quotient width
    localparam int NUM_W   = 14;  // (mag - dz) * 100 <= 10000
    localparam int SQ_W    = 14;  // linear * linear <= 10000
    localparam int DUTY_W  = 15;  // unsigned duty registers
    localparam int PROD_W  = 23;  // signed (max - min) * curve
    localparam int PABS_W  = 22;  // magnitude of the above
    localparam int OUT_W   = 16;  // signed duty

    localparam int DIV_STEPS = MAG_W;

    localparam logic signed [CMD_W-1:0] CMD_LIMIT = 16'sd100;
    localparam logic [MAG_W-1:0]        PCT_FULL  = 7'd100;

    // floor(x / 100) for x <= 10000: (x * 5243) >> 19
    localparam int                SQ_RECIP_W = 13;
    localparam logic [12:0]       SQ_RECIP   = 13'd5243;
    localparam int                SQ_SHIFT   = 19;

    // floor(x / 100) for x < 2**22: (x * ceil(2**29 / 100)) >> 29
    localparam int                PCT_RECIP_W = 23;
    localparam logic [22:0]       PCT_RECIP   = 23'd5368710;
    localparam int                PCT_SHIFT   = 29;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_DEADZONE = 2'd0,
        REG_MIN_DUTY = 2'd1,
        REG_MAX_DUTY = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic zero;  // command inside deadzone
        logic neg;   // command below zero
    } side_t;

endpackage

// ===== rtl/core/pcurve_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcurve_div: pipelined restoring divider
// One quotient bit per register stage; side-band flags travel with the data.
// ----------------------------------------------------------------------------
module pcurve_div
    import pcurve_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [MAG_W-1:0] den,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [MAG_W-1:0] quot,
    output side_t            out_side
);

    logic [DIV_STEPS-1:0] valid_reg;
    logic [NUM_W-1:0]     rem_reg  [DIV_STEPS];
    logic [MAG_W-1:0]     den_reg  [DIV_STEPS];
    logic [MAG_W-1:0]     q_reg    [DIV_STEPS];
    side_t                side_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int B = DIV_STEPS - 1 - k;

        logic             prev_valid;
        logic [NUM_W-1:0] prev_rem;
        logic [MAG_W-1:0] prev_den;
        logic [MAG_W-1:0] prev_q;
        side_t            prev_side;
        logic [NUM_W-1:0] dshift;
        logic [NUM_W-1:0] rem_next;
        logic [MAG_W-1:0] q_next;

        if (k == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = num;
            assign prev_den   = den;
            assign prev_q     = '0;
            assign prev_side  = in_side;
        end
        else begin : g_rest
            assign prev_valid = valid_reg[k-1];
            assign prev_rem   = rem_reg[k-1];
            assign prev_den   = den_reg[k-1];
            assign prev_q     = q_reg[k-1];
            assign prev_side  = side_reg[k-1];
        end

        assign dshift = NUM_W'(prev_den) << B;

        always_comb
        begin
            if (prev_rem >= dshift)
            begin
                rem_next = prev_rem - dshift;
                q_next   = prev_q | (MAG_W'(1) << B);
            end
            else
            begin
                rem_next = prev_rem;
                q_next   = prev_q;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= prev_den;
                q_reg[k]    <= q_next;
                side_reg[k] <= prev_side;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign quot      = q_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

`ifndef SYNTHESIS
    // outside the deadzone the rescaled value never exceeds full scale
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_side.zero) |-> (quot <= PCT_FULL))
        else $error("divider quotient above full scale");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(valid_reg) && $stable(quot) && $stable(out_side)))
        else $error("divider pipeline moved while stalled");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (en && in_valid) |=> valid_reg[0])
        else $error("transfer lost at divider entry");
`endif

endmodule

// ===== rtl/core/percent_to_pwm_curve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_to_pwm_curve: deadband plus quadratic throttle curve
//
// s_axis carries a signed percent command (tdata[15:0]); m_axis returns the
// signed PWM duty (tdata[15:0]), one result per command, in order.
// The command is clamped to +/-100, zeroed inside the deadzone, rescaled
// over the span above it, squared, scaled between min and max duty, clamped
// and given back its sign.
// Throughput: one command per cycle while the output is not stalled; the
// datapath is a 15-stage pipeline, the linear rescale being a 7-stage
// restoring divider (one bit per stage).
// Stall: when the output register holds a result that is not taken, the
// whole pipeline freezes and s_axis_tready drops; nothing is lost.
// Reset: pipeline emptied, deadzone 5, min duty 0, max duty 255.
// Registers (APB, byte address): 0x0 deadzone_percent, 0x4
// min_effective_duty, 0x8 max_duty. Write them only while the block is idle.
// ----------------------------------------------------------------------------
module percent_to_pwm_curve
    import pcurve_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // command stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,  // [15:0] command_percent
    // duty stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata   // [15:0] signed_duty
);

    // ---------------- configuration ----------------
    logic [MAG_W-1:0]  dz_reg;
    logic [DUTY_W-1:0] mn_reg;
    logic [DUTY_W-1:0] mx_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg <= MAG_W'(5);
            mn_reg <= '0;
            mx_reg <= DUTY_W'(255);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DEADZONE: dz_reg <= pwdata[MAG_W-1:0];
                REG_MIN_DUTY: mn_reg <= pwdata[DUTY_W-1:0];
                REG_MAX_DUTY: mx_reg <= pwdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_DEADZONE: prdata = APB_DW'(dz_reg);
            REG_MIN_DUTY: prdata = APB_DW'(mn_reg);
            REG_MAX_DUTY: prdata = APB_DW'(mx_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic in_xfer;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // stage 1: clamp, sign/magnitude, deadzone test, divider operands
    logic signed [CMD_W-1:0] cmd;
    logic signed [CMD_W-1:0] cmd_sat;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        over_dz;
    logic [NUM_W-1:0]        s1_num_next;
    logic [MAG_W-1:0]        s1_den_next;
    side_t                   s1_side_next;

    always_comb
    begin
        cmd = $signed(s_axis_tdata);
        if (cmd > CMD_LIMIT)
            cmd_sat = CMD_LIMIT;
        else if (cmd < -CMD_LIMIT)
            cmd_sat = -CMD_LIMIT;
        else
            cmd_sat = cmd;
        s1_side_next.neg = cmd_sat[CMD_W-1];
        mag = s1_side_next.neg ? MAG_W'(-cmd_sat) : MAG_W'(cmd_sat);
        s1_side_next.zero = (mag <= dz_reg);
        // only meaningful outside the deadzone, where dz <= 99
        over_dz     = mag - dz_reg;
        s1_num_next = NUM_W'(over_dz) * NUM_W'(PCT_FULL);
        s1_den_next = PCT_FULL - dz_reg;
    end

    logic             s1_valid_reg;
    logic [NUM_W-1:0] s1_num_reg;
    logic [MAG_W-1:0] s1_den_reg;
    side_t            s1_side_reg;

    // stages 2..8: linear = num / den
    logic             dv_valid;
    logic [MAG_W-1:0] dv_quot;
    side_t            dv_side;

    pcurve_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .num       (s1_num_reg),
        .den       (s1_den_reg),
        .in_side   (s1_side_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_side  (dv_side)
    );

    // stage 9: square
    logic [SQ_W-1:0] sq_next;
    logic            sq_valid_reg;
    logic [SQ_W-1:0] sq_reg;
    side_t           sq_side_reg;

    assign sq_next = SQ_W'(dv_quot) * SQ_W'(dv_quot);

    // stage 10: curve = square / 100
    logic [SQ_W+SQ_RECIP_W-1:0] cv_prod;
    logic [MAG_W-1:0]           cv_next;
    logic                       cv_valid_reg;
    logic [MAG_W-1:0]           cv_reg;
    side_t                      cv_side_reg;

    assign cv_prod = (SQ_W+SQ_RECIP_W)'(sq_reg) * (SQ_W+SQ_RECIP_W)'(SQ_RECIP);
    assign cv_next = cv_prod[SQ_SHIFT +: MAG_W];

    // stage 11: (max - min) * curve
    logic signed [OUT_W:0]    span;
    logic signed [PROD_W:0]   pr_full;
    logic signed [PROD_W-1:0] pr_next;
    logic                     pr_valid_reg;
    logic signed [PROD_W-1:0] pr_reg;
    side_t                    pr_side_reg;

    assign span    = $signed({2'b00, mx_reg}) - $signed({2'b00, mn_reg});
    assign pr_full = (PROD_W+1)'(span) * $signed({1'b0, cv_reg});
    assign pr_next = pr_full[PROD_W-1:0];

    // stage 12: magnitude of the product
    logic [PABS_W-1:0] ab_next;
    logic              ab_valid_reg;
    logic [PABS_W-1:0] ab_reg;
    logic              ab_pneg_reg;
    side_t             ab_side_reg;

    assign ab_next = pr_reg[PROD_W-1] ? PABS_W'(-pr_reg) : PABS_W'(pr_reg);

    // stage 13: magnitude / 100, truncation toward zero
    logic [PABS_W+PCT_RECIP_W-1:0] qt_prod;
    logic [DUTY_W-1:0]             qt_next;
    logic                          qt_valid_reg;
    logic [DUTY_W-1:0]             qt_reg;
    logic                          qt_pneg_reg;
    side_t                         qt_side_reg;

    assign qt_prod = (PABS_W+PCT_RECIP_W)'(ab_reg) * (PABS_W+PCT_RECIP_W)'(PCT_RECIP);
    assign qt_next = qt_prod[PCT_SHIFT +: DUTY_W];

    // stage 14: offset by min duty and clamp to 0..max
    logic signed [DUTY_W+1:0] dt_sum;
    logic [DUTY_W-1:0]        dt_next;
    logic                     dt_valid_reg;
    logic [DUTY_W-1:0]        dt_reg;
    side_t                    dt_side_reg;

    always_comb
    begin
        if (qt_pneg_reg)
            dt_sum = $signed({2'b00, mn_reg}) - $signed({2'b00, qt_reg});
        else
            dt_sum = $signed({2'b00, mn_reg}) + $signed({2'b00, qt_reg});
        if (dt_sum < 0)
            dt_next = '0;
        else if (dt_sum > $signed({2'b00, mx_reg}))
            dt_next = mx_reg;
        else
            dt_next = dt_sum[DUTY_W-1:0];
    end

    // stage 15: output register, sign restored
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;

    always_comb
    begin
        if (dt_side_reg.zero)
            out_data_next = '0;
        else if (dt_side_reg.neg)
            out_data_next = -OUT_W'(dt_reg);
        else
            out_data_next = OUT_W'(dt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            cv_valid_reg  <= 1'b0;
            pr_valid_reg  <= 1'b0;
            ab_valid_reg  <= 1'b0;
            qt_valid_reg  <= 1'b0;
            dt_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_xfer;
            sq_valid_reg  <= dv_valid;
            cv_valid_reg  <= sq_valid_reg;
            pr_valid_reg  <= cv_valid_reg;
            ab_valid_reg  <= pr_valid_reg;
            qt_valid_reg  <= ab_valid_reg;
            dt_valid_reg  <= qt_valid_reg;
            out_valid_reg <= dt_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_num_reg   <= s1_num_next;
            s1_den_reg   <= s1_den_next;
            s1_side_reg  <= s1_side_next;
            sq_reg       <= sq_next;
            sq_side_reg  <= dv_side;
            cv_reg       <= cv_next;
            cv_side_reg  <= sq_side_reg;
            pr_reg       <= pr_next;
            pr_side_reg  <= cv_side_reg;
            ab_reg       <= ab_next;
            ab_pneg_reg  <= pr_reg[PROD_W-1];
            ab_side_reg  <= pr_side_reg;
            qt_reg       <= qt_next;
            qt_pneg_reg  <= ab_pneg_reg;
            qt_side_reg  <= ab_side_reg;
            dt_reg       <= dt_next;
            dt_side_reg  <= qt_side_reg;
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (($signed(m_axis_tdata) <= $signed({1'b0, mx_reg})) &&
             ($signed(m_axis_tdata) >= -$signed({1'b0, mx_reg}))))
        else $error("duty magnitude above max_duty");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("accepted transfer not in first stage");
`endif

endmodule
